[sv/odrgb_pkg.sv]
// odrgb_pkg: shared types, constants and dither matrix for the rgb 3-3-2 dither packer
package odrgb_pkg;

    typedef logic [7:0] level_t;
    typedef logic [3:0] dither_t;
    typedef logic [1:0] phase_t;

    localparam logic [2:0] RED_TOP   = 3'd7;
    localparam logic [2:0] GREEN_TOP = 3'd7;
    localparam logic [1:0] BLUE_TOP  = 2'd3;

    function automatic dither_t bayer_entry(input phase_t row, input phase_t col);
        dither_t entry;
        begin
            entry = 4'd0;
            unique case ({row, col})
                4'h0: entry = 4'd0;
                4'h1: entry = 4'd8;
                4'h2: entry = 4'd2;
                4'h3: entry = 4'd10;
                4'h4: entry = 4'd12;
                4'h5: entry = 4'd4;
                4'h6: entry = 4'd14;
                4'h7: entry = 4'd6;
                4'h8: entry = 4'd3;
                4'h9: entry = 4'd11;
                4'ha: entry = 4'd1;
                4'hb: entry = 4'd9;
                4'hc: entry = 4'd15;
                4'hd: entry = 4'd7;
                4'he: entry = 4'd13;
                4'hf: entry = 4'd5;
                default: entry = 4'd0;
            endcase
            return entry;
        end
    endfunction

endpackage

[sv/odrgb_pack.sv]
// odrgb_pack: scales three colour planes and packs them into one dithered 3-3-2 byte
module odrgb_pack (
    input  odrgb_pkg::level_t  red_level,
    input  odrgb_pkg::level_t  green_level,
    input  odrgb_pkg::level_t  blue_level,
    input  odrgb_pkg::dither_t threshold,
    output odrgb_pkg::level_t  packed_pixel
);
    import odrgb_pkg::*;

    logic [10:0] red_prod;
    logic [10:0] green_prod;
    logic [9:0]  blue_prod;
    logic [7:0]  red_t;
    logic [7:0]  green_t;
    logic [7:0]  blue_t;
    logic [2:0]  red_out;
    logic [2:0]  green_out;
    logic [1:0]  blue_out;

    assign red_prod   = {3'b000, red_level} * 11'd7;
    assign green_prod = {3'b000, green_level} * 11'd7;
    assign blue_prod  = {2'b00, blue_level} * 10'd3;

    assign red_t   = red_prod[10:3];
    assign green_t = green_prod[10:3];
    assign blue_t  = blue_prod[9:2];

    always_comb
    begin
        red_out = red_t[7:5];
        if (red_t[7:5] != RED_TOP && red_t[4:1] > threshold)
        begin
            red_out = red_t[7:5] + 3'd1;
        end

        green_out = green_t[7:5];
        if (green_t[7:5] != GREEN_TOP && green_t[4:1] > threshold)
        begin
            green_out = green_t[7:5] + 3'd1;
        end

        blue_out = blue_t[7:6];
        if (blue_t[7:6] != BLUE_TOP && blue_t[5:2] > threshold)
        begin
            blue_out = blue_t[7:6] + 2'd1;
        end
    end

    assign packed_pixel = {red_out, green_out, blue_out};

endmodule

[sv/ordered_dither_rgb332_top.sv]
// ordered_dither_rgb332_top: 4x4 ordered-dither packer from 8-bit rgb planes to 3-3-2 bytes
// Takes one pixel item per clock and returns one packed byte per item; an accepted item passes
// through an input register holding the pixel and its matrix threshold, then a result register
// holding the packed byte, from which it is offered. Full rate holds while the output side takes
// results; a stalled result is held while one more item waits in the input register. Column and
// row phases start at zero after reset, are cleared by frame_start before that pixel is dithered,
// and line_end returns the column to zero and steps the row.
module ordered_dither_rgb332_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  odrgb_pkg::level_t  red_level,
    input  odrgb_pkg::level_t  green_level,
    input  odrgb_pkg::level_t  blue_level,
    input  logic               frame_start,
    input  logic               line_end,
    output logic               out_valid,
    input  logic               out_ready,
    output odrgb_pkg::level_t  packed_pixel
);
    import odrgb_pkg::*;

    phase_t  col_phase_reg;
    phase_t  col_phase_next;
    phase_t  row_phase_reg;
    phase_t  row_phase_next;
    phase_t  col_used;
    phase_t  row_used;

    logic    s1_valid_reg;
    level_t  s1_red_reg;
    level_t  s1_green_reg;
    level_t  s1_blue_reg;
    dither_t s1_thresh_reg;

    logic    out_valid_reg;
    level_t  out_pixel_reg;
    level_t  pack_result;

    logic    in_fire;
    logic    s1_advance;
    logic    s2_ready;

    assign s2_ready   = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s2_ready;
    assign in_fire    = in_valid && in_ready;
    assign s1_advance = s1_valid_reg && s2_ready;

    // phases in use for this pixel
    assign col_used = frame_start ? 2'd0 : col_phase_reg;
    assign row_used = frame_start ? 2'd0 : row_phase_reg;

    always_comb
    begin
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if (in_fire)
        begin
            if (line_end)
            begin
                col_phase_next = 2'd0;
                row_phase_next = row_used + 2'd1;
            end
            else
            begin
                col_phase_next = col_used + 2'd1;
                row_phase_next = row_used;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_phase_reg <= 2'd0;
            row_phase_reg <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_red_reg    <= red_level;
            s1_green_reg  <= green_level;
            s1_blue_reg   <= blue_level;
            s1_thresh_reg <= bayer_entry(row_used, col_used);
        end
        if (s1_advance)
        begin
            out_pixel_reg <= pack_result;
        end
    end

    odrgb_pack u_pack (
        .red_level    (s1_red_reg),
        .green_level  (s1_green_reg),
        .blue_level   (s1_blue_reg),
        .threshold    (s1_thresh_reg),
        .packed_pixel (pack_result)
    );

    assign out_valid    = out_valid_reg;
    assign packed_pixel = out_pixel_reg;

    // end of line returns the column to zero
    a_line_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && line_end) |=> (col_phase_reg == 2'd0))
        else $error("column phase not cleared after line end");

    // frame start without line end leaves row zero and column one
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_start && !line_end) |=>
        (row_phase_reg == 2'd0 && col_phase_reg == 2'd1))
        else $error("phases wrong after frame start");

    // phases hold when no item is taken
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> ($stable(col_phase_reg) && $stable(row_phase_reg)))
        else $error("phase moved without an item");

    // a staged item is never dropped while the result register is stalled
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_thresh_reg)))
        else $error("staged item lost under stall");

endmodule

[bench/ordered_dither_rgb332_checker.sv]
// checker for the rgb 3-3-2 dither packer: tracks phases, predicts packed bytes, compares results
`timescale 1ns / 100ps

module ordered_dither_rgb332_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  odrgb_pkg::level_t red_level,
    input  odrgb_pkg::level_t green_level,
    input  odrgb_pkg::level_t blue_level,
    input  logic              frame_start,
    input  logic              line_end,
    input  logic              out_valid,
    input  logic              out_ready,
    input  odrgb_pkg::level_t packed_pixel,
    output int                mismatches,
    output int                outstanding
);
    import odrgb_pkg::*;

    // bayer thresholds, row-major, entry (0,0) in the low nibble
    localparam logic [63:0] BAYER_THRESHOLDS = 64'h5D7F91B36E4CA280;

    phase_t col_phase;
    phase_t row_phase;
    level_t expected_pixels [$];
    int     fail_total = 0;
    int     pending_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_total;

    function automatic level_t dither_pack(input level_t red, input level_t green,
                                           input level_t blue, input dither_t threshold);
        logic [10:0] red_scaled;
        logic [10:0] green_scaled;
        logic [9:0]  blue_scaled;
        logic [2:0]  red_out;
        logic [2:0]  green_out;
        logic [1:0]  blue_out;
        begin
            red_scaled   = ({3'b000, red} * 11'd7) >> 3;
            green_scaled = ({3'b000, green} * 11'd7) >> 3;
            blue_scaled  = ({2'b00, blue} * 10'd3) >> 2;
            red_out   = red_scaled[7:5];
            green_out = green_scaled[7:5];
            blue_out  = blue_scaled[7:6];
            // green takes its fraction from the same bit positions as red
            if (red_out != RED_TOP && red_scaled[4:1] > threshold)
                red_out = red_out + 3'd1;
            if (green_out != GREEN_TOP && green_scaled[4:1] > threshold)
                green_out = green_out + 3'd1;
            if (blue_out != BLUE_TOP && blue_scaled[5:2] > threshold)
                blue_out = blue_out + 2'd1;
            return {red_out, green_out, blue_out};
        end
    endfunction

    task automatic flag_mismatch(input string what, input level_t got, input level_t want);
        begin
            $display("%0t ns: %s: got %02h want %02h", $time, what, got, want);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        phase_t  use_row;
        phase_t  use_col;
        dither_t threshold;
        level_t  want;
        if (!rst_n)
        begin
            col_phase = '0;
            row_phase = '0;
            expected_pixels.delete();
            pending_total = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    flag_mismatch("packed_pixel with no item pending", packed_pixel, 8'h00);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (packed_pixel !== want)
                        flag_mismatch("packed_pixel", packed_pixel, want);
                end
            end
            if (in_valid && in_ready)
            begin
                use_row = frame_start ? phase_t'(0) : row_phase;
                use_col = frame_start ? phase_t'(0) : col_phase;
                threshold = BAYER_THRESHOLDS[{use_row, use_col} * 4 +: 4];
                expected_pixels.push_back(dither_pack(red_level, green_level, blue_level,
                                                      threshold));
                if (line_end)
                begin
                    col_phase = '0;
                    row_phase = use_row + phase_t'(1);
                end
                else
                begin
                    col_phase = use_col + phase_t'(1);
                    row_phase = use_row;
                end
            end
            pending_total = expected_pixels.size();
        end
    end

endmodule

[bench/tb.sv]
// testbench top for the rgb 3-3-2 dither packer: clock, reset, pixel stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import odrgb_pkg::*;

    localparam int NUM_RANDOM   = 500;
    localparam int GAP_MAX      = 19;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    level_t red_level = '0;
    level_t green_level = '0;
    level_t blue_level = '0;
    logic   frame_start = 1'b0;
    logic   line_end = 1'b0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    level_t packed_pixel;
    int     mismatches;
    int     outstanding;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_off = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ordered_dither_rgb332_top DUT (.*);

    ordered_dither_rgb332_checker checker_i (.*);

    function automatic level_t pick_level();
        begin
            case ($urandom_range(0, 7))
                0: return 8'h00;
                1: return 8'hff;
                default: return level_t'($urandom);
            endcase
        end
    endfunction

    task automatic send_pixel(input level_t r, input level_t g, input level_t b,
                              input logic fs, input logic le);
        int gap;
        begin
            gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0)
            begin
                in_valid    = 1'b0;
                red_level   = level_t'($urandom);
                green_level = level_t'($urandom);
                blue_level  = level_t'($urandom);
                frame_start = 1'($urandom_range(0, 1));
                line_end    = 1'($urandom_range(0, 1));
                repeat (gap) @(negedge clk);
            end
            red_level   = r;
            green_level = g;
            blue_level  = b;
            frame_start = fs;
            line_end    = le;
            in_valid    = 1'b1;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // result side: random stalls per item, one long hold-off on request
    initial
    begin : drain_results
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
                if (stall > 0)
                begin
                    out_ready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int   random_done;
        int   lines;
        int   line_len;
        bit   pressure_done;
        logic fs;
        logic le;
        random_done   = 0;
        pressure_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes on the first row
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
        send_pixel(8'hff, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 8'hff, 8'h00, 1'b0, 1'b1);
        // remaining rows walk every matrix entry
        for (int k = 0; k < 12; k++)
            send_pixel(level_t'(16 * k + 9), level_t'(255 - 16 * k), level_t'(16 * k + 5),
                       1'b0, (k % 4) == 3);
        send_pixel(8'h00, 8'h00, 8'hff, 1'b0, 1'b0);
        // frame start and line end on one pixel
        send_pixel(8'h80, 8'h80, 8'h80, 1'b1, 1'b1);
        send_pixel(8'd91, 8'd164, 8'd200, 1'b0, 1'b0);
        send_pixel(8'd73, 8'd73, 8'd73, 1'b0, 1'b0);
        // frame start in mid-line
        send_pixel(8'd250, 8'd5, 8'd129, 1'b1, 1'b0);

        while (random_done < NUM_RANDOM)
        begin
            if (!pressure_done && random_done >= NUM_RANDOM / 2)
            begin
                hold_off = 1'b1;
                tx_burst = 1'b1;
                for (int k = 0; k < 40; k++)
                    send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, (k % 4) == 3);
                random_done += 40;
                tx_burst = 1'b0;
                pressure_done = 1'b1;
            end
            lines = $urandom_range(1, 6);
            for (int l = 0; l < lines; l++)
            begin
                line_len = $urandom_range(1, 8);
                for (int p = 0; p < line_len; p++)
                begin
                    fs = (l == 0 && p == 0);
                    le = (p == line_len - 1);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        fs = 1'($urandom_range(0, 1));
                        le = 1'($urandom_range(0, 1));
                    end
                    send_pixel(pick_level(), pick_level(), pick_level(), fs, le);
                    random_done++;
                end
                if ($urandom_range(0, 7) == 0)
                    tx_burst = !tx_burst;
            end
        end
        in_valid = 1'b0;

        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[ordered_dither_rgb332_top.f]
sv/odrgb_pkg.sv
sv/odrgb_pack.sv
sv/ordered_dither_rgb332_top.sv
bench/ordered_dither_rgb332_checker.sv
bench/tb.sv
